/* src/fralu_pkg.sv */
// Shared types, operation codes and decode helpers for the four-register ALU machine.
package fralu_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 2;
   localparam int FIELD_WIDTH        = 32;

   typedef logic [3:0] kind_type;
   typedef logic [1:0] idx_type;

   localparam kind_type OP_ADDR = 4'd0;
   localparam kind_type OP_ADDI = 4'd1;
   localparam kind_type OP_MULR = 4'd2;
   localparam kind_type OP_MULI = 4'd3;
   localparam kind_type OP_BANR = 4'd4;
   localparam kind_type OP_BANI = 4'd5;
   localparam kind_type OP_BORR = 4'd6;
   localparam kind_type OP_BORI = 4'd7;
   localparam kind_type OP_SETR = 4'd8;
   localparam kind_type OP_SETI = 4'd9;
   localparam kind_type OP_GTIR = 4'd10;
   localparam kind_type OP_GTRI = 4'd11;
   localparam kind_type OP_GTRR = 4'd12;
   localparam kind_type OP_EQIR = 4'd13;
   localparam kind_type OP_EQRI = 4'd14;
   localparam kind_type OP_EQRR = 4'd15;

   typedef struct packed {
      kind_type kind;
      idx_type  dest;
      logic     a_reg;
      logic     b_reg;
      idx_type  a_idx;
      idx_type  b_idx;
      logic     bad;
   } ctl_type;

   function automatic logic uses_a_reg(input kind_type kind);
      logic r;
      case (kind)
         OP_SETI, OP_GTIR, OP_EQIR: r = 1'b0;
         default:                   r = 1'b1;
      endcase
      return r;
   endfunction

   function automatic logic uses_b_reg(input kind_type kind);
      logic r;
      case (kind)
         OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
         OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: r = 1'b1;
         default:                            r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

/* src/four_register_alu_machine_unit.sv */
// Top level of the four-register ALU machine: front queue feeding the execute stage.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    kind, operand_a, operand_b, dest_index
//   rsp      out        rsp_valid/stall    reg0..reg3 values, bad_index
//
// One item per cycle sustained while rsp_stall is low. An accepted item is written
// into the front queue at the accepting edge and is then executed into the output
// register, which raises rsp_valid.
// The back end reads, computes and writes the register file in the cycle in which it
// pops the item, which sets the rate.
// Reset clears the register file to zero and empties the queue.
// rsp_stall holds the output register; the two-entry queue then fills and raises req_stall.
module four_register_alu_machine_unit #(
   parameter int DATA_WIDTH = fralu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fralu_pkg::kind_type                   req_kind,
   input  logic signed [fralu_pkg::FIELD_WIDTH-1:0] req_operand_a,
   input  logic signed [fralu_pkg::FIELD_WIDTH-1:0] req_operand_b,
   input  fralu_pkg::idx_type                    req_dest_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fralu_pkg::FIELD_WIDTH-1:0] rsp_reg0_value,
   output logic signed [fralu_pkg::FIELD_WIDTH-1:0] rsp_reg1_value,
   output logic signed [fralu_pkg::FIELD_WIDTH-1:0] rsp_reg2_value,
   output logic signed [fralu_pkg::FIELD_WIDTH-1:0] rsp_reg3_value,
   output logic                                  rsp_bad_index
);
   import fralu_pkg::*;

   logic                  q_valid;
   logic                  q_pop;
   ctl_type               q_ctl;
   logic [DATA_WIDTH-1:0] q_a_imm;
   logic [DATA_WIDTH-1:0] q_b_imm;

   fralu_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_dest_index (req_dest_index),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_ctl          (q_ctl),
      .q_a_imm        (q_a_imm),
      .q_b_imm        (q_b_imm)
   );

   fralu_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_ctl          (q_ctl),
      .q_a_imm        (q_a_imm),
      .q_b_imm        (q_b_imm),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg0_value (rsp_reg0_value),
      .rsp_reg1_value (rsp_reg1_value),
      .rsp_reg2_value (rsp_reg2_value),
      .rsp_reg3_value (rsp_reg3_value),
      .rsp_bad_index  (rsp_bad_index)
   );

endmodule

/* src/fralu_front.sv */
// Front end: accepts instruction items, classifies operands and queues them for execution.
module fralu_front #(
   parameter int DATA_WIDTH = fralu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fralu_pkg::kind_type                   req_kind,
   input  logic signed [fralu_pkg::FIELD_WIDTH-1:0] req_operand_a,
   input  logic signed [fralu_pkg::FIELD_WIDTH-1:0] req_operand_b,
   input  fralu_pkg::idx_type                    req_dest_index,
   output logic                                  q_valid,
   input  logic                                  q_pop,
   output fralu_pkg::ctl_type                    q_ctl,
   output logic [DATA_WIDTH-1:0]                 q_a_imm,
   output logic [DATA_WIDTH-1:0]                 q_b_imm
);
   import fralu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ctl_type               ctl_ff   [QUEUE_DEPTH];
   logic [DATA_WIDTH-1:0] a_imm_ff [QUEUE_DEPTH];
   logic [DATA_WIDTH-1:0] b_imm_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   ctl_type               ctl_new;
   logic [DATA_WIDTH-1:0] a_imm_new;
   logic [DATA_WIDTH-1:0] b_imm_new;
   logic                  push;
   logic                  a_reg;
   logic                  b_reg;

   assign a_reg     = uses_a_reg(req_kind);
   assign b_reg     = uses_b_reg(req_kind);
   assign a_imm_new = DATA_WIDTH'(req_operand_a);
   assign b_imm_new = DATA_WIDTH'(req_operand_b);

   always_comb begin
      ctl_new.kind  = req_kind;
      ctl_new.dest  = req_dest_index;
      ctl_new.a_reg = a_reg;
      ctl_new.b_reg = b_reg;
      ctl_new.a_idx = req_operand_a[1:0];
      ctl_new.b_idx = req_operand_b[1:0];
      ctl_new.bad   = (a_reg && (|req_operand_a[FIELD_WIDTH-1:2]))
                   || (b_reg && (|req_operand_b[FIELD_WIDTH-1:2]));
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   assign q_valid = (count_ff != '0);
   assign q_ctl   = ctl_ff[rd_ptr_ff];
   assign q_a_imm = a_imm_ff[rd_ptr_ff];
   assign q_b_imm = b_imm_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]   <= ctl_new;
         a_imm_ff[wr_ptr_ff] <= a_imm_new;
         b_imm_ff[wr_ptr_ff] <= b_imm_new;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_pop_count: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");

endmodule

/* src/fralu_back.sv */
// Back end: executes queued instructions on the register file and holds the result item.
module fralu_back #(
   parameter int DATA_WIDTH = fralu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   output logic                                  q_pop,
   input  fralu_pkg::ctl_type                    q_ctl,
   input  logic [DATA_WIDTH-1:0]                 q_a_imm,
   input  logic [DATA_WIDTH-1:0]                 q_b_imm,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fralu_pkg::FIELD_WIDTH-1:0] rsp_reg0_value,
   output logic signed [fralu_pkg::FIELD_WIDTH-1:0] rsp_reg1_value,
   output logic signed [fralu_pkg::FIELD_WIDTH-1:0] rsp_reg2_value,
   output logic signed [fralu_pkg::FIELD_WIDTH-1:0] rsp_reg3_value,
   output logic                                  rsp_bad_index
);
   import fralu_pkg::*;

   logic [DATA_WIDTH-1:0]  rf_ff [4];
   logic [DATA_WIDTH-1:0]  rf_in [4];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] out_ff [4];
   logic                   bad_ff;

   logic                   fire;
   logic [DATA_WIDTH-1:0]  a_val;
   logic [DATA_WIDTH-1:0]  b_val;
   logic [DATA_WIDTH-1:0]  result;

   assign fire  = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = fire;

   assign a_val = q_ctl.a_reg ? rf_ff[q_ctl.a_idx] : q_a_imm;
   assign b_val = q_ctl.b_reg ? rf_ff[q_ctl.b_idx] : q_b_imm;

   always_comb begin
      case (q_ctl.kind)
         OP_ADDR, OP_ADDI:          result = a_val + b_val;
         OP_MULR, OP_MULI:          result = DATA_WIDTH'(a_val * b_val);
         OP_BANR, OP_BANI:          result = a_val & b_val;
         OP_BORR, OP_BORI:          result = a_val | b_val;
         OP_SETR, OP_SETI:          result = a_val;
         OP_GTIR, OP_GTRI, OP_GTRR:
            result = DATA_WIDTH'($signed(a_val) > $signed(b_val));
         OP_EQIR, OP_EQRI, OP_EQRR: result = DATA_WIDTH'(a_val == b_val);
         default:                   result = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rf_in[i] = rf_ff[i];
      end
      if (fire && !q_ctl.bad) begin
         rf_in[q_ctl.dest] = result;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            rf_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) begin
            rf_ff[i] <= rf_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         bad_ff <= q_ctl.bad;
         for (int i = 0; i < 4; i++) begin
            out_ff[i] <= FIELD_WIDTH'(rf_in[i]);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg0_value = out_ff[0];
   assign rsp_reg1_value = out_ff[1];
   assign rsp_reg2_value = out_ff[2];
   assign rsp_reg3_value = out_ff[3];
   assign rsp_bad_index  = bad_ff;

   a_fire_shows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("executed item not presented");

   a_bad_flag: assert property (@(posedge clock) disable iff (reset)
      fire |=> bad_ff == $past(q_ctl.bad))
      else $error("bad index flag mismatch");

   a_bad_no_write: assert property (@(posedge clock) disable iff (reset)
      (fire && q_ctl.bad) |=> (rf_ff[0] == $past(rf_ff[0])) && (rf_ff[1] == $past(rf_ff[1]))
         && (rf_ff[2] == $past(rf_ff[2])) && (rf_ff[3] == $past(rf_ff[3])))
      else $error("register written on bad index");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> (rf_ff[0] == $past(rf_ff[0])) && (rf_ff[3] == $past(rf_ff[3])))
      else $error("register file changed without an item");

endmodule

/* sim/four_register_alu_machine_unit_tb.sv */
// Testbench for four_register_alu_machine_unit: directed and random programs vs a predictor.
`timescale 1ns / 100ps

module four_register_alu_machine_unit_tb;
   import fralu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] reg0;
      logic [31:0] reg1;
      logic [31:0] reg2;
      logic [31:0] reg3;
      logic        bad;
   } reg_snapshot_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   kind_type                req_kind = OP_ADDR;
   logic signed [31:0]      req_operand_a = '0;
   logic signed [31:0]      req_operand_b = '0;
   idx_type                 req_dest_index = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [31:0]      rsp_reg0_value;
   logic signed [31:0]      rsp_reg1_value;
   logic signed [31:0]      rsp_reg2_value;
   logic signed [31:0]      rsp_reg3_value;
   logic                    rsp_bad_index;

   logic [31:0]             arch_regs [4] = '{default: '0};
   reg_snapshot_type        expected_q [$];
   int                      fail_count = 0;
   int                      cycle_count = 0;
   int                      send_idle_pct = 0;
   int                      stall_pct = 0;

   four_register_alu_machine_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_dest_index (req_dest_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg0_value (rsp_reg0_value),
      .rsp_reg1_value (rsp_reg1_value),
      .rsp_reg2_value (rsp_reg2_value),
      .rsp_reg3_value (rsp_reg3_value),
      .rsp_bad_index  (rsp_bad_index)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("four_register_alu_machine_unit_tb failed");
         $finish;
      end
   end

   // bit 0: operand a names a register, bit 1: operand b names a register
   function automatic logic [1:0] operand_roles(input kind_type k);
      logic [1:0] roles;
      case (k)
         OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: roles = 2'b11;
         OP_GTIR, OP_EQIR:                                    roles = 2'b10;
         OP_SETI:                                             roles = 2'b00;
         default:                                             roles = 2'b01;
      endcase
      return roles;
   endfunction

   function automatic reg_snapshot_type execute_instruction(input kind_type k,
                                                            input logic [31:0] a,
                                                            input logic [31:0] b,
                                                            input idx_type d);
      logic [1:0]       roles;
      logic [31:0]      x;
      logic [31:0]      y;
      logic [31:0]      r;
      reg_snapshot_type snap;
      roles = operand_roles(k);
      snap.bad = (roles[0] && a > 32'd3) || (roles[1] && b > 32'd3);
      if (!snap.bad) begin
         x = roles[0] ? arch_regs[a[1:0]] : a;
         y = roles[1] ? arch_regs[b[1:0]] : b;
         case (k)
            OP_ADDR, OP_ADDI:          r = x + y;
            OP_MULR, OP_MULI:          r = x * y;
            OP_BANR, OP_BANI:          r = x & y;
            OP_BORR, OP_BORI:          r = x | y;
            OP_SETR, OP_SETI:          r = x;
            OP_GTIR, OP_GTRI, OP_GTRR: r = ($signed(x) > $signed(y)) ? 32'd1 : 32'd0;
            default:                   r = (x == y) ? 32'd1 : 32'd0;
         endcase
         arch_regs[d] = r;
      end
      snap.reg0 = arch_regs[0];
      snap.reg1 = arch_regs[1];
      snap.reg2 = arch_regs[2];
      snap.reg3 = arch_regs[3];
      return snap;
   endfunction

   task automatic send_item(input kind_type k, input logic [31:0] a, input logic [31:0] b,
                            input idx_type d);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= k;
      req_operand_a  <= a;
      req_operand_b  <= b;
      req_dest_index <= d;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      expected_q.push_back(execute_instruction(k, a, b, d));
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %h actual %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      reg_snapshot_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("item on rsp with nothing expected");
            fail_count++;
         end else begin
            exp = expected_q.pop_front();
            check_field("reg0_value", exp.reg0, rsp_reg0_value);
            check_field("reg1_value", exp.reg1, rsp_reg1_value);
            check_field("reg2_value", exp.reg2, rsp_reg2_value);
            check_field("reg3_value", exp.reg3, rsp_reg3_value);
            check_field("bad_index", {31'd0, exp.bad}, {31'd0, rsp_bad_index});
         end
      end
   end

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(7))
         0:       w = 32'h8000_0000;
         1:       w = 32'h7fff_ffff;
         2:       w = 32'hffff_ffff;
         3:       w = 32'h0000_0000;
         4, 5:    w = $urandom;
         default: w = $urandom_range(20) - 10;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] pick_register_operand();
      logic [31:0] w;
      case ($urandom_range(39))
         0:       w = 32'd4;
         1:       w = 32'hffff_ffff;
         2:       w = $urandom;
         3:       w = 32'h8000_0000;
         default: w = $urandom_range(3);
      endcase
      return w;
   endfunction

   task automatic test_load_and_arith();
      send_item(OP_SETI, 32'h7fff_ffff, 32'h0000_0000, 2'd0);
      send_item(OP_SETI, 32'h8000_0000, 32'hffff_ffff, 2'd1);
      send_item(OP_SETI, 32'hffff_ffff, 32'h8000_0000, 2'd2);
      send_item(OP_ADDR, 32'd0, 32'd0, 2'd3);
      send_item(OP_ADDI, 32'd1, 32'hffff_ffff, 2'd3);
      send_item(OP_MULR, 32'd0, 32'd1, 2'd3);
      send_item(OP_MULI, 32'd2, 32'h8000_0000, 2'd3);
      send_item(OP_SETR, 32'd0, 32'h7fff_ffff, 2'd3);
   endtask

   task automatic test_logic_and_compare();
      send_item(OP_BANI, 32'd2, 32'h0f0f_0f0f, 2'd3);
      send_item(OP_BANR, 32'd0, 32'd3, 2'd2);
      send_item(OP_BORI, 32'd2, 32'h8000_0000, 2'd2);
      send_item(OP_BORR, 32'd1, 32'd3, 2'd3);
      send_item(OP_GTIR, 32'hffff_ffff, 32'd1, 2'd3);
      send_item(OP_GTRI, 32'd0, 32'h8000_0000, 2'd3);
      send_item(OP_GTRR, 32'd1, 32'd0, 2'd3);
      send_item(OP_EQIR, 32'h7fff_ffff, 32'd0, 2'd3);
      send_item(OP_EQRI, 32'd1, 32'h8000_0000, 2'd2);
      send_item(OP_EQRR, 32'd0, 32'd0, 2'd1);
   endtask

   task automatic test_bad_operands();
      send_item(OP_ADDR, 32'd4, 32'd0, 2'd0);
      send_item(OP_ADDI, 32'hffff_ffff, 32'd5, 2'd1);
      send_item(OP_GTIR, 32'h8000_0000, 32'h8000_0000, 2'd2);
      send_item(OP_EQRR, 32'd1, 32'h7fff_ffff, 2'd3);
      send_item(OP_SETR, 32'd4, 32'd0, 2'd0);
      send_item(OP_SETI, 32'hdead_beef, 32'hffff_fffc, 2'd0);
      // hold off until the pipe has drained
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_random_programs(input int count);
      kind_type    k;
      logic [1:0]  roles;
      logic [31:0] a;
      logic [31:0] b;
      for (int i = 0; i < count; i++) begin
         k = ($urandom_range(4) == 0) ? OP_SETI : kind_type'($urandom_range(15));
         roles = operand_roles(k);
         a = roles[0] ? pick_register_operand() : pick_word();
         b = roles[1] ? pick_register_operand() : pick_word();
         send_item(k, a, b, idx_type'($urandom_range(3)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 16;
      stall_pct     = 52;
      test_load_and_arith();
      test_logic_and_compare();
      test_bad_operands();
      test_random_programs(430);
      send_idle_pct = 52;
      stall_pct     = 16;
      test_random_programs(430);
      send_idle_pct = 0;
      stall_pct     = 0;
      test_random_programs(440);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("four_register_alu_machine_unit_tb passed");
      end else begin
         $display("four_register_alu_machine_unit_tb failed");
      end
      $finish;
   end

endmodule
